// ----- sv/pfe_pkg.sv -----
// ============================================================================
// pfe_pkg
// Shared types and constants of the postfix expression evaluator.
// ============================================================================
package pfe_pkg;

    localparam int DATA_W      = 48;
    localparam int FRAC_BITS   = 16;
    localparam int STACK_DEPTH = 16;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int HALF_W      = DATA_W / 2;
    localparam int MAG_W       = 2 * DATA_W;
    localparam int DIV_STEPS   = DATA_W + FRAC_BITS;
    localparam int DIV_CW      = $clog2(DIV_STEPS + 1);
    localparam int WGT_W       = FRAC_BITS;
    localparam int WQ_W        = FRAC_BITS + 1 + 32;
    localparam int RECIP_SHIFT = 35;

    localparam logic [31:0]        RECIP10    = 32'hCCCC_CCCD;
    localparam logic [WGT_W-1:0]   WGT_START  = WGT_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [DATA_W-1:0]  VMAX       = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0]  VMIN       = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        K_NOP,
        K_DIGIT,
        K_POINT,
        K_PUSH,
        K_OP,
        K_ERR
    } kind_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef struct packed {
        kind_t      kind;
        op_t        op;
        logic [3:0] digit;
        logic       last;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV,
        ST_SAT,
        ST_WB,
        ST_OUT
    } state_t;

endpackage

// ----- sv/postfix_expression_evaluator.sv -----
// ============================================================================
// postfix_expression_evaluator
// Streams postfix characters in, returns one fixed-point result per expression.
// ============================================================================
// Input channel s_*: one ASCII character per request in s_tdata[7:0], s_tlast
// marks the final character of an expression. Output channel m_*: one request
// per expression, given after its last character.
// A character is classified on entry and queued (two entries); the back end
// takes one queued item at a time. Digits, points, spaces and other characters
// pass the IDLE and EXEC states of the back end; + and - add WB; * adds
// MUL_LO, MUL_HI and SAT (two 48x24 partial products) before WB; / with a
// nonzero divisor adds DIV, the restoring divider that yields one quotient bit
// per cycle (48 + fraction bits), then SAT and WB. The last character adds the
// OUT state, which loads the output register when it is free.
// Reset clears the stack count, the number being built and all flags; stack
// contents need no clearing. When m_tready stays low, the output register
// holds the result, the back end waits on its next result and the queue then
// fills, dropping s_tready.
// ============================================================================
module postfix_expression_evaluator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [0] ok, [48:1] value, [49] saturated, zero pad
);

    pfe_pkg::item_t              front_item;
    pfe_pkg::item_t              q_item;
    logic                        q_full;
    logic                        q_valid;
    logic                        q_pop;
    logic                        res_ok;
    logic [pfe_pkg::DATA_W-1:0]  res_value;
    logic                        res_sat;

    assign s_tready = !q_full;

    pfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_char  (s_tdata),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .item     (front_item)
    );

    pfe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid && s_tready),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (q_item)
    );

    pfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ok    (res_ok),
        .out_value (res_value),
        .out_sat   (res_sat)
    );

    assign m_tdata = {6'd0, res_sat, res_value, res_ok};

endmodule

// ----- sv/pfe_ram.sv -----
// ============================================================================
// pfe_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module pfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/pfe_front.sv -----
// ============================================================================
// pfe_front
// Classifies each character; spaces and operators against the previous one.
// ============================================================================
module pfe_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [7:0]    in_char,
    input  logic          in_last,
    input  logic          in_ready,
    output pfe_pkg::item_t item
);

    logic [7:0] prev_reg;
    logic [7:0] prev_next;
    logic       is_digit;
    logic       prev_digit;

    assign is_digit   = (in_char >= pfe_pkg::CH_ZERO) && (in_char <= pfe_pkg::CH_NINE);
    assign prev_digit = (prev_reg >= pfe_pkg::CH_ZERO) && (prev_reg <= pfe_pkg::CH_NINE);

    always_comb
    begin
        item.kind  = pfe_pkg::K_NOP;
        item.op    = pfe_pkg::OP_ADD;
        item.digit = 4'(in_char - pfe_pkg::CH_ZERO);
        item.last  = in_last;
        case (in_char)
            pfe_pkg::CH_POINT: item.kind = pfe_pkg::K_POINT;
            pfe_pkg::CH_SPACE:
            begin
                if (prev_reg == pfe_pkg::CH_SPACE)
                    item.kind = pfe_pkg::K_ERR;
                else if (prev_digit)
                    item.kind = pfe_pkg::K_PUSH;
            end
            pfe_pkg::CH_PLUS, pfe_pkg::CH_MINUS, pfe_pkg::CH_STAR, pfe_pkg::CH_SLASH:
            begin
                item.kind = (prev_reg == pfe_pkg::CH_SPACE) ? pfe_pkg::K_OP : pfe_pkg::K_ERR;
                if (in_char == pfe_pkg::CH_MINUS)
                    item.op = pfe_pkg::OP_SUB;
                else if (in_char == pfe_pkg::CH_STAR)
                    item.op = pfe_pkg::OP_MUL;
                else if (in_char == pfe_pkg::CH_SLASH)
                    item.op = pfe_pkg::OP_DIV;
            end
            default:
            begin
                if (is_digit)
                    item.kind = pfe_pkg::K_DIGIT;
            end
        endcase
    end

    always_comb
    begin
        prev_next = prev_reg;
        if (in_valid && in_ready)
            prev_next = in_last ? 8'd0 : in_char;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_reg <= 8'd0;
        else
            prev_reg <= prev_next;
    end

endmodule

// ----- sv/pfe_queue.sv -----
// ============================================================================
// pfe_queue
// Two-entry queue of classified items between front and back.
// ============================================================================
module pfe_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pfe_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output pfe_pkg::item_t pop_item
);

    pfe_pkg::item_t slot_reg [2];
    logic           wptr_reg, wptr_next;
    logic           rptr_reg, rptr_next;
    logic [1:0]     fill_reg, fill_next;

    assign full      = fill_reg == 2'd2;
    assign not_empty = fill_reg != 2'd0;
    assign pop_item  = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        fill_next = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ----- sv/pfe_back.sv -----
// ============================================================================
// pfe_back
// Executes classified items: number build, value stack, arithmetic, result.
// ============================================================================
module pfe_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  pfe_pkg::item_t               q_item,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_ok,
    output logic [pfe_pkg::DATA_W-1:0]   out_value,
    output logic                         out_sat
);

    pfe_pkg::state_t state_reg, state_next;
    pfe_pkg::item_t  cur_reg;

    logic [pfe_pkg::CNT_W-1:0]     cnt_reg;
    logic [pfe_pkg::DATA_W-1:0]    acc_reg;
    logic [pfe_pkg::WGT_W-1:0]     wgt_reg;
    logic                          point_reg;
    logic                          err_reg;
    logic                          opdone_reg;
    logic                          sat_reg;
    logic [pfe_pkg::DATA_W-1:0]    top_reg;
    logic [pfe_pkg::DATA_W-1:0]    res_reg;
    logic [pfe_pkg::DATA_W-1:0]    ma_reg;
    logic [pfe_pkg::DATA_W-1:0]    mb_reg;
    logic                          neg_reg;
    logic [pfe_pkg::MAG_W-1:0]     prod_reg;
    logic [pfe_pkg::MAG_W-1:0]     mag_reg;
    logic [pfe_pkg::DIV_STEPS-1:0] dvd_reg;
    logic [pfe_pkg::DIV_STEPS-1:0] quo_reg;
    logic [pfe_pkg::DATA_W:0]      rem_reg;
    logic [pfe_pkg::DIV_CW-1:0]    dcnt_reg;

    logic                          ovalid_reg;
    logic                          ook_reg;
    logic [pfe_pkg::DATA_W-1:0]    oval_reg;
    logic                          osat_reg;

    logic                          ram_we;
    logic [pfe_pkg::PTR_W-1:0]     ram_waddr;
    logic [pfe_pkg::DATA_W-1:0]    ram_wdata;
    logic [pfe_pkg::PTR_W-1:0]     ram_raddr;
    logic [pfe_pkg::DATA_W-1:0]    lhs;

    logic                          live;
    logic                          do_push;
    logic                          op_ok;
    logic                          out_load;
    logic [pfe_pkg::DATA_W+4:0]    int_sum;
    logic [pfe_pkg::DATA_W:0]      frac_sum;
    logic [pfe_pkg::WGT_W:0]       wgt_x;
    logic [pfe_pkg::WQ_W-1:0]      wgt_prod;
    logic [pfe_pkg::DATA_W:0]      addsub;
    logic [pfe_pkg::DATA_W+pfe_pkg::HALF_W-1:0] pp;
    logic [pfe_pkg::DATA_W:0]      rem_sh;
    logic                          rem_ge;
    logic [pfe_pkg::CNT_W-1:0]     cnt_m2;

    pfe_ram #(
        .WIDTH (pfe_pkg::DATA_W),
        .DEPTH (pfe_pkg::STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (lhs)
    );

    assign cnt_m2   = cnt_reg - pfe_pkg::CNT_W'(2);
    assign live     = !err_reg;
    assign do_push  = live && (cur_reg.kind == pfe_pkg::K_PUSH)
                      && (cnt_reg < pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH));
    assign op_ok    = live && (cur_reg.kind == pfe_pkg::K_OP) && (cnt_reg >= pfe_pkg::CNT_W'(2));
    assign out_load = (state_reg == pfe_pkg::ST_OUT) && (!ovalid_reg || out_ready);

    assign int_sum  = ((pfe_pkg::DATA_W+5)'(acc_reg) << 3) + ((pfe_pkg::DATA_W+5)'(acc_reg) << 1)
                      + ((pfe_pkg::DATA_W+5)'(cur_reg.digit) << pfe_pkg::FRAC_BITS);
    assign frac_sum = (pfe_pkg::DATA_W+1)'(acc_reg)
                      + (pfe_pkg::DATA_W+1)'(cur_reg.digit) * (pfe_pkg::DATA_W+1)'(wgt_reg);
    assign wgt_x    = (pfe_pkg::WGT_W+1)'(wgt_reg) + (pfe_pkg::WGT_W+1)'(5);
    assign wgt_prod = pfe_pkg::WQ_W'(wgt_x) * pfe_pkg::WQ_W'(pfe_pkg::RECIP10);
    assign addsub   = (cur_reg.op == pfe_pkg::OP_SUB)
                      ? {lhs[pfe_pkg::DATA_W-1], lhs} - {top_reg[pfe_pkg::DATA_W-1], top_reg}
                      : {lhs[pfe_pkg::DATA_W-1], lhs} + {top_reg[pfe_pkg::DATA_W-1], top_reg};
    assign pp       = (state_reg == pfe_pkg::ST_MUL_LO)
                      ? ma_reg * mb_reg[pfe_pkg::HALF_W-1:0]
                      : ma_reg * mb_reg[pfe_pkg::DATA_W-1:pfe_pkg::HALF_W];
    assign rem_sh   = {rem_reg[pfe_pkg::DATA_W-1:0], dvd_reg[pfe_pkg::DIV_STEPS-1]};
    assign rem_ge   = rem_sh >= {1'b0, mb_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfe_pkg::ST_IDLE:
                if (q_valid)
                    state_next = pfe_pkg::ST_EXEC;
            pfe_pkg::ST_EXEC:
            begin
                if (!op_ok)
                    state_next = cur_reg.last ? pfe_pkg::ST_OUT : pfe_pkg::ST_IDLE;
                else if (cur_reg.op == pfe_pkg::OP_MUL)
                    state_next = pfe_pkg::ST_MUL_LO;
                else if (cur_reg.op == pfe_pkg::OP_DIV && top_reg != '0)
                    state_next = pfe_pkg::ST_DIV;
                else
                    state_next = pfe_pkg::ST_WB;
            end
            pfe_pkg::ST_MUL_LO: state_next = pfe_pkg::ST_MUL_HI;
            pfe_pkg::ST_MUL_HI: state_next = pfe_pkg::ST_SAT;
            pfe_pkg::ST_DIV:
                if (dcnt_reg == pfe_pkg::DIV_CW'(1))
                    state_next = pfe_pkg::ST_SAT;
            pfe_pkg::ST_SAT: state_next = pfe_pkg::ST_WB;
            pfe_pkg::ST_WB:
                state_next = cur_reg.last ? pfe_pkg::ST_OUT : pfe_pkg::ST_IDLE;
            pfe_pkg::ST_OUT:
                if (out_load)
                    state_next = pfe_pkg::ST_IDLE;
            default: state_next = pfe_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = cnt_reg[pfe_pkg::PTR_W-1:0];
        ram_wdata = acc_reg;
        ram_raddr = cnt_m2[pfe_pkg::PTR_W-1:0];
        case (state_reg)
            pfe_pkg::ST_IDLE: q_pop = q_valid;
            pfe_pkg::ST_EXEC: ram_we = do_push;
            pfe_pkg::ST_WB:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_m2[pfe_pkg::PTR_W-1:0];
                ram_wdata = res_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_item;
        case (state_reg)
            pfe_pkg::ST_EXEC:
            begin
                if (cur_reg.op == pfe_pkg::OP_DIV && top_reg == '0)
                    res_reg <= lhs[pfe_pkg::DATA_W-1] ? pfe_pkg::VMIN : pfe_pkg::VMAX;
                else if (addsub[pfe_pkg::DATA_W] != addsub[pfe_pkg::DATA_W-1])
                    res_reg <= addsub[pfe_pkg::DATA_W] ? pfe_pkg::VMIN : pfe_pkg::VMAX;
                else
                    res_reg <= addsub[pfe_pkg::DATA_W-1:0];
                ma_reg   <= lhs[pfe_pkg::DATA_W-1] ? -lhs : lhs;
                mb_reg   <= top_reg[pfe_pkg::DATA_W-1] ? -top_reg : top_reg;
                neg_reg  <= lhs[pfe_pkg::DATA_W-1] ^ top_reg[pfe_pkg::DATA_W-1];
                dvd_reg  <= {(lhs[pfe_pkg::DATA_W-1] ? -lhs : lhs), {pfe_pkg::FRAC_BITS{1'b0}}};
                quo_reg  <= '0;
                rem_reg  <= '0;
                dcnt_reg <= pfe_pkg::DIV_CW'(pfe_pkg::DIV_STEPS);
            end
            pfe_pkg::ST_MUL_LO:
                prod_reg <= pfe_pkg::MAG_W'(pp);
            pfe_pkg::ST_MUL_HI:
                mag_reg <= (prod_reg + (pfe_pkg::MAG_W'(pp) << pfe_pkg::HALF_W))
                           >> pfe_pkg::FRAC_BITS;
            pfe_pkg::ST_DIV:
            begin
                dvd_reg  <= dvd_reg << 1;
                rem_reg  <= rem_ge ? rem_sh - {1'b0, mb_reg} : rem_sh;
                quo_reg  <= {quo_reg[pfe_pkg::DIV_STEPS-2:0], rem_ge};
                dcnt_reg <= dcnt_reg - pfe_pkg::DIV_CW'(1);
                if (dcnt_reg == pfe_pkg::DIV_CW'(1))
                    mag_reg <= pfe_pkg::MAG_W'({quo_reg[pfe_pkg::DIV_STEPS-2:0], rem_ge});
            end
            pfe_pkg::ST_SAT:
            begin
                if (neg_reg)
                    res_reg <= (mag_reg > pfe_pkg::MAG_W'(pfe_pkg::VMIN))
                               ? pfe_pkg::VMIN : -mag_reg[pfe_pkg::DATA_W-1:0];
                else
                    res_reg <= (mag_reg > pfe_pkg::MAG_W'(pfe_pkg::VMAX))
                               ? pfe_pkg::VMAX : mag_reg[pfe_pkg::DATA_W-1:0];
            end
            default: ;
        endcase
        if (out_load)
        begin
            ook_reg  <= !err_reg && cnt_reg == pfe_pkg::CNT_W'(1) && opdone_reg;
            oval_reg <= (!err_reg && cnt_reg == pfe_pkg::CNT_W'(1) && opdone_reg) ? top_reg : '0;
            osat_reg <= sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pfe_pkg::ST_IDLE;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            wgt_reg    <= pfe_pkg::WGT_START;
            point_reg  <= 1'b0;
            err_reg    <= 1'b0;
            opdone_reg <= 1'b0;
            sat_reg    <= 1'b0;
            top_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                pfe_pkg::ST_EXEC:
                begin
                    if (live)
                    begin
                        case (cur_reg.kind)
                            pfe_pkg::K_DIGIT:
                            begin
                                if (cur_reg.last)
                                    err_reg <= 1'b1;
                                else if (point_reg)
                                begin
                                    wgt_reg <= pfe_pkg::WGT_W'(wgt_prod >> pfe_pkg::RECIP_SHIFT);
                                    if (frac_sum > (pfe_pkg::DATA_W+1)'(pfe_pkg::VMAX))
                                    begin
                                        acc_reg <= pfe_pkg::VMAX;
                                        sat_reg <= 1'b1;
                                    end
                                    else
                                        acc_reg <= frac_sum[pfe_pkg::DATA_W-1:0];
                                end
                                else if (int_sum > (pfe_pkg::DATA_W+5)'(pfe_pkg::VMAX))
                                begin
                                    acc_reg <= pfe_pkg::VMAX;
                                    sat_reg <= 1'b1;
                                end
                                else
                                    acc_reg <= int_sum[pfe_pkg::DATA_W-1:0];
                            end
                            pfe_pkg::K_POINT: point_reg <= 1'b1;
                            pfe_pkg::K_PUSH:
                            begin
                                if (do_push)
                                begin
                                    top_reg   <= acc_reg;
                                    cnt_reg   <= cnt_reg + pfe_pkg::CNT_W'(1);
                                    acc_reg   <= '0;
                                    wgt_reg   <= pfe_pkg::WGT_START;
                                    point_reg <= 1'b0;
                                end
                                else
                                    err_reg <= 1'b1;
                            end
                            pfe_pkg::K_OP:
                            begin
                                if (!op_ok)
                                    err_reg <= 1'b1;
                                else if ((cur_reg.op == pfe_pkg::OP_DIV && top_reg == '0)
                                         || ((cur_reg.op == pfe_pkg::OP_ADD
                                              || cur_reg.op == pfe_pkg::OP_SUB)
                                             && addsub[pfe_pkg::DATA_W]
                                                != addsub[pfe_pkg::DATA_W-1]))
                                    sat_reg <= 1'b1;
                            end
                            pfe_pkg::K_ERR: err_reg <= 1'b1;
                            default: ;
                        endcase
                    end
                end
                pfe_pkg::ST_SAT:
                begin
                    if (neg_reg ? (mag_reg > pfe_pkg::MAG_W'(pfe_pkg::VMIN))
                                : (mag_reg > pfe_pkg::MAG_W'(pfe_pkg::VMAX)))
                        sat_reg <= 1'b1;
                end
                pfe_pkg::ST_WB:
                begin
                    top_reg    <= res_reg;
                    cnt_reg    <= cnt_reg - pfe_pkg::CNT_W'(1);
                    opdone_reg <= 1'b1;
                end
                pfe_pkg::ST_OUT:
                begin
                    if (out_load)
                    begin
                        cnt_reg    <= '0;
                        acc_reg    <= '0;
                        wgt_reg    <= pfe_pkg::WGT_START;
                        point_reg  <= 1'b0;
                        err_reg    <= 1'b0;
                        opdone_reg <= 1'b0;
                        sat_reg    <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_valid = ovalid_reg;
    assign out_ok    = ook_reg;
    assign out_value = oval_reg;
    assign out_sat   = osat_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    a_wb_two: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pfe_pkg::ST_WB |-> cnt_reg >= pfe_pkg::CNT_W'(2))
        else $error("write-back with fewer than two values");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pfe_pkg::ST_DIV |-> mb_reg != '0)
        else $error("divider running on zero divisor");

    a_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> cnt_reg == '0 && !err_reg && !sat_reg && out_valid)
        else $error("state not cleared after result");

endmodule
